// ===== sv/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned KEY_WIDTH   = 20;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FUNC_WIDTH  = 2;
  localparam int unsigned CNT_WIDTH   = $clog2(CAPACITY + 1);

  localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_DELETE = 2'd2;

  // request broadcast along the row of cells
  typedef struct packed {
    logic                   go;
    logic [FUNC_WIDTH-1:0]  func;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic                   hit_any;
    logic                   full;
  } cell_cmd_t;

  // what each cell reports back
  typedef struct packed {
    logic                   match;
    logic [VALUE_WIDTH-1:0] value;
  } cell_stat_t;

endpackage

// ===== sv/cht_cell.sv =====
module cht_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cht_pkg::cell_cmd_t  cmd_i,
  input  logic                free_i,
  output logic                free_o,
  output cht_pkg::cell_stat_t stat_o
);

  logic                            valid_q, valid_d;
  logic [cht_pkg::KEY_WIDTH-1:0]   key_q, key_d;
  logic [cht_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic                            match;

  assign match  = valid_q && (key_q == cmd_i.key);
  assign free_o = free_i || !valid_q;

  assign stat_o.match = match;
  assign stat_o.value = match ? value_q : '0;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (cmd_i.go) begin
      case (cmd_i.func)
        cht_pkg::FUNC_INSERT: begin
          if (!cmd_i.full) begin
            if (match) begin
              value_d = cmd_i.value;
            end else if (!cmd_i.hit_any && !valid_q && !free_i) begin
              // first free cell of the row claims the new entry
              valid_d = 1'b1;
              key_d   = cmd_i.key;
              value_d = cmd_i.value;
            end
          end
        end
        cht_pkg::FUNC_DELETE: begin
          if (match) begin
            valid_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

// ===== sv/chained_hash_table_store_top.sv =====
// key-value store with room for 32 entries, searched by key in every cell
//
// request channel: a beat is taken at the rising edge where start_i is high
// and busy_o is low; func_i selects insert-or-update, lookup or delete.
// result channel: done_o is high for exactly one cycle with success_o,
// value_out_o and entry_count_o; the receiver must take it then.
//
// a request taken at a rising edge is executed by the row of cells in the
// following cycle; its result is registered in the result register and shown
// with done_o in the cycle after that. a new request is not taken while one
// executes. busy_o is high during the execute cycle only, so a new start_i may
// coincide with done_o.
//
// equal keys always fall into the same bucket, so a bucket is a subset of
// cells and a plain key compare in every cell finds the entry; a new key
// goes to the lowest-numbered free cell, found by a free chain along the row.
// insert is refused whenever the store is full, even for a present key.
//
// reset (rst_ni low) empties every cell at once and clears the count; no
// clearing sweep is needed.
module chained_hash_table_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [19:0] key_i,
  input  logic [31:0] value_in_i,
  output logic        done_o,
  output logic        success_o,
  output logic [31:0] value_out_o,
  output logic [5:0]  entry_count_o
);

  localparam int unsigned N = cht_pkg::CAPACITY;

  // request register
  logic                              busy_q, busy_d;
  logic [cht_pkg::FUNC_WIDTH-1:0]    func_q;
  logic [cht_pkg::KEY_WIDTH-1:0]     key_q;
  logic [cht_pkg::VALUE_WIDTH-1:0]   val_q;

  // result register
  logic                              done_q;
  logic                              succ_q, succ_d;
  logic [cht_pkg::VALUE_WIDTH-1:0]   vout_q, vout_d;
  logic [cht_pkg::CNT_WIDTH-1:0]     cnt_q, cnt_d;

  cht_pkg::cell_cmd_t                cmd;
  cht_pkg::cell_stat_t               stat [N];
  logic [N:0]                        free_chain;
  logic                              hit_any;
  logic [cht_pkg::VALUE_WIDTH-1:0]   hit_value;
  logic                              full;
  logic                              accept;

  assign accept = start_i && !busy_q;
  assign busy_d = accept;
  assign full   = (cnt_q == cht_pkg::CNT_WIDTH'(N));

  // at most one cell matches, so an or over the gated values picks the hit
  always_comb begin
    hit_any   = 1'b0;
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      hit_any   = hit_any | stat[i].match;
      hit_value = hit_value | stat[i].value;
    end
  end

  assign cmd.go      = busy_q;
  assign cmd.func    = func_q;
  assign cmd.key     = key_q;
  assign cmd.value   = val_q;
  assign cmd.hit_any = hit_any;
  assign cmd.full    = full;

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    cht_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .free_i (free_chain[g]),
      .free_o (free_chain[g+1]),
      .stat_o (stat[g])
    );
  end

  // outcome of the executing request
  always_comb begin
    succ_d = 1'b0;
    vout_d = '0;
    cnt_d  = cnt_q;
    case (func_q)
      cht_pkg::FUNC_INSERT: begin
        if (!full) begin
          if (hit_any) begin
            succ_d = 1'b1;
          end else if (free_chain[N]) begin
            succ_d = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
        end
      end
      cht_pkg::FUNC_LOOKUP: begin
        if (hit_any) begin
          succ_d = 1'b1;
          vout_d = hit_value;
        end
      end
      cht_pkg::FUNC_DELETE: begin
        if (hit_any) begin
          succ_d = 1'b1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= busy_q;
      if (busy_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= key_i;
      val_q  <= value_in_i;
    end
    if (busy_q) begin
      succ_q <= succ_d;
      vout_q <= vout_d;
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign success_o     = succ_q;
  assign value_out_o   = vout_q;
  assign entry_count_o = cnt_q;

endmodule

// ===== sv/cht_checker.sv =====
module cht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        success_o,
  input logic [31:0] value_out_o,
  input logic [5:0]  entry_count_o
);

  // an accepted beat raises busy_o in the following cycle, while it holds the cell row
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted request");

  // every accepted beat yields a result once it has passed the execute cycle
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("result missing two cycles after request");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && !$past(done_o))
    else $error("result strobe overlaps execute cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !success_o |-> value_out_o == 32'd0)
    else $error("non-zero value on failed request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> entry_count_o <= 6'(cht_pkg::CAPACITY))
    else $error("entry count above capacity");

endmodule

bind chained_hash_table_store_top cht_checker u_cht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .success_o     (success_o),
  .value_out_o   (value_out_o),
  .entry_count_o (entry_count_o)
);

// ===== tb/kv_store_check_pkg.sv =====
package kv_store_check_pkg;

  import cht_pkg::*;

  // func code with no operation behind it
  localparam logic [FUNC_WIDTH-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic                   success;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_WIDTH-1:0]   count;
  } store_reply_t;

  class kv_store_scoreboard;

    logic [KEY_WIDTH-1:0]   cell_key[CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_value[CAPACITY];
    bit                     cell_used[CAPACITY];
    int unsigned            n_stored;
    store_reply_t           replies_due[$];
    int unsigned            n_errors;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        cell_key[i]   = '0;
        cell_value[i] = '0;
        cell_used[i]  = 1'b0;
      end
      n_stored  = 0;
      n_errors  = 0;
    endfunction

    // equal keys share a bucket, so a plain key compare finds the entry
    function int find_cell(logic [KEY_WIDTH-1:0] k);
      for (int i = 0; i < CAPACITY; i++) begin
        if (cell_used[i] && cell_key[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [FUNC_WIDTH-1:0] f, logic [KEY_WIDTH-1:0] k,
                               logic [VALUE_WIDTH-1:0] v);
      store_reply_t r;
      int           slot;
      r    = '0;
      slot = find_cell(k);
      case (f)
        FUNC_INSERT: begin
          // full store refuses even an update
          if (n_stored < CAPACITY) begin
            if (slot >= 0) begin
              cell_value[slot] = v;
              r.success        = 1'b1;
            end else begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (!cell_used[i]) begin
                  cell_used[i]  = 1'b1;
                  cell_key[i]   = k;
                  cell_value[i] = v;
                  n_stored++;
                  r.success     = 1'b1;
                  break;
                end
              end
            end
          end
        end
        FUNC_LOOKUP: begin
          if (slot >= 0) begin
            r.success = 1'b1;
            r.value   = cell_value[slot];
          end
        end
        FUNC_DELETE: begin
          if (slot >= 0) begin
            cell_used[slot]  = 1'b0;
            cell_key[slot]   = '0;
            cell_value[slot] = '0;
            n_stored--;
            r.success        = 1'b1;
          end
        end
        default: ;
      endcase
      r.count     = CNT_WIDTH'(n_stored);
      replies_due = {replies_due, r};
    endfunction

    function void check_reply(logic s, logic [VALUE_WIDTH-1:0] vo, logic [CNT_WIDTH-1:0] c);
      store_reply_t r;
      if (replies_due.size() == 0) begin
        $error("result beat with no request outstanding");
        n_errors++;
        return;
      end
      r = replies_due.pop_front();
      if (s !== r.success) begin
        $error("success: expected %0d, got %0d", r.success, s);
        n_errors++;
      end
      if (vo !== r.value) begin
        $error("value_out: expected %08h, got %08h", r.value, vo);
        n_errors++;
      end
      if (c !== r.count) begin
        $error("entry_count: expected %0d, got %0d", r.count, c);
        n_errors++;
      end
    endfunction

    function int unsigned outstanding();
      return replies_due.size();
    endfunction

  endclass

endpackage

// ===== tb/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;
  import kv_store_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned N_RANDOM    = 800;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [19:0] key_i;
  logic [31:0] value_in_i;
  logic        done_o;
  logic        success_o;
  logic [31:0] value_out_o;
  logic [5:0]  entry_count_o;

  kv_store_scoreboard sb = new();

  // keys used by the random part; more keys than cells so the store fills
  logic [KEY_WIDTH-1:0] key_pool[POOL_SIZE];
  int unsigned          n_cycles;

  chained_hash_table_store_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .success_o    (success_o),
    .value_out_o  (value_out_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // both channels watched at the rising edge; outputs still hold their old
  // values here, so a result beat is checked before the request beat taken
  // at the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        sb.check_reply(success_o, value_out_o, entry_count_o);
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        sb.note_request(func_i, key_i, value_in_i);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic issue(input logic [1:0] f, input logic [19:0] k, input logic [31:0] v);
    logic taken;
    start_i    <= 1'b1;
    func_i     <= f;
    key_i      <= k;
    value_in_i <= v;
    do begin
      @(posedge clk_i);
      taken = (busy_o === 1'b0);
    end while (!taken);
    @(negedge clk_i);
  endtask

  // start is only lowered when a real gap follows, never dropped and
  // raised again in the same step
  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_WIDTH'($urandom);
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // mode 0 fills, mode 1 is balanced, mode 2 drains
  task automatic issue_random(input int unsigned mode);
    int unsigned r;
    logic [1:0]  f;
    r = $urandom_range(0, 99);
    case (mode)
      0: f = (r < 65) ? FUNC_INSERT : (r < 85) ? FUNC_LOOKUP : (r < 95) ? FUNC_DELETE
                                                                         : FUNC_NONE;
      1: f = (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_LOOKUP : (r < 95) ? FUNC_DELETE
                                                                         : FUNC_NONE;
      default: f = (r < 15) ? FUNC_INSERT : (r < 45) ? FUNC_LOOKUP : (r < 95) ? FUNC_DELETE
                                                                              : FUNC_NONE;
    endcase
    issue(f, pick_key(), $urandom);
  endtask

  initial begin
    int unsigned n_sent;
    int unsigned burst;
    int unsigned mode;

    n_cycles   = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    func_i     = FUNC_INSERT;
    key_i      = '0;
    value_in_i = '0;

    // distinct keys (index in the top bits), the first eight share one bucket
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {6'(i), 14'($urandom)};
      if (i < 8) key_pool[i][4:0] = 5'd7;
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, field extremes, a chain of two in bucket 0,
    // update, delete from the chain, unused func code
    issue(FUNC_LOOKUP, 20'h00000, 32'hFFFF_FFFF);
    issue(FUNC_DELETE, 20'hFFFFF, 32'h0000_0000);
    issue(FUNC_NONE,   20'hFFFFF, 32'hFFFF_FFFF);
    hold_off(1);
    issue(FUNC_INSERT, 20'h00000, 32'h0000_0000);
    issue(FUNC_INSERT, 20'hFFFFF, 32'hFFFF_FFFF);
    issue(FUNC_INSERT, 20'h00020, 32'hA5A5_A5A5);
    hold_off(2);
    issue(FUNC_LOOKUP, 20'h00020, 32'h0000_0000);
    issue(FUNC_LOOKUP, 20'h00000, 32'h0000_0000);
    issue(FUNC_LOOKUP, 20'hFFFFF, 32'h0000_0000);
    issue(FUNC_INSERT, 20'h00000, 32'h5A5A_5A5A);
    issue(FUNC_LOOKUP, 20'h00000, 32'h0000_0000);
    hold_off(1);
    issue(FUNC_DELETE, 20'h00020, 32'h0000_0000);
    issue(FUNC_LOOKUP, 20'h00020, 32'h0000_0000);
    issue(FUNC_LOOKUP, 20'h00000, 32'h0000_0000);
    issue(FUNC_DELETE, 20'h00020, 32'h0000_0000);
    issue(FUNC_NONE,   20'h00000, 32'h0000_0000);
    issue(FUNC_INSERT, 20'h00040, 32'h1234_5678);
    issue(FUNC_DELETE, 20'h00000, 32'h0000_0000);
    issue(FUNC_DELETE, 20'hFFFFF, 32'h0000_0000);
    issue(FUNC_DELETE, 20'h00040, 32'h0000_0000);

    // fill the now empty store to the brim with distinct keys, then poke it
    for (int i = 0; i < CAPACITY; i++) begin
      issue(FUNC_INSERT, key_pool[i], $urandom);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
    end
    issue(FUNC_INSERT, key_pool[0], $urandom);    // update refused while full
    issue(FUNC_INSERT, key_pool[35], $urandom);   // new key refused while full
    issue(FUNC_LOOKUP, key_pool[3], '0);
    issue(FUNC_DELETE, key_pool[7], '0);
    issue(FUNC_INSERT, key_pool[35], $urandom);   // fits again
    issue(FUNC_INSERT, key_pool[0], $urandom);    // full again, refused

    // sender pauses until every result is home
    hold_off(1);
    wait_drained();
    @(negedge clk_i);

    // random part in bursts, each with its own mix of operations
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      mode  = $urandom_range(0, 2);
      for (int i = 0; i < burst && n_sent < N_RANDOM; i++) begin
        issue_random(mode);
        n_sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;                                   // back-to-back burst
        3:       hold_off($urandom_range(10, 20));
        default: hold_off($urandom_range(1, 6));
      endcase
    end

    hold_off(1);
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== chained_hash_table_store_top.f =====
sv/cht_pkg.sv
sv/cht_cell.sv
sv/chained_hash_table_store_top.sv
sv/cht_checker.sv
tb/kv_store_check_pkg.sv
tb/tb_top.sv
